// File: src/csf_pkg.sv
// Shared types and constants for the delimited-line field splitter.
package csf_pkg;

    localparam logic [7:0] QUOTE_BYTE  = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] SPACE_BYTE  = 8'h20;
    localparam logic [7:0] TAB_BYTE    = 8'h09;
    localparam logic [7:0] CR_BYTE     = 8'h0D;

    // One input beat: a line byte or an end-of-line marker.
    typedef struct packed {
        logic       req_type;
        logic [7:0] line_byte;
    } req_t;

    // One result beat: a field's position and flags.
    typedef struct packed {
        logic [15:0] field_offset;
        logic [15:0] field_length;
        logic        was_quoted;
        logic        last_in_line;
        logic        too_long;
    } rsp_t;

    // A classified input beat, as queued between the front and the back.
    typedef struct packed {
        logic eol;
        logic is_quote;
        logic is_delim;
        logic is_space;
    } cls_t;

endpackage

// File: src/csf_front.sv
// Front end: input handshake, delimiter register and byte classification.
module csf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_wdata,
    input  logic            in_valid,
    input  csf_pkg::req_t   in_data,
    input  logic            q_full,
    output logic            in_ready,
    output logic            push,
    output csf_pkg::cls_t   cls
);

    logic [7:0] delimiter_reg;
    logic [7:0] delimiter_next;
    logic [7:0] b;

    always_comb
    begin
        delimiter_next = cfg_we ? cfg_wdata : delimiter_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= csf_pkg::DELIM_RESET;
        end
        else
        begin
            delimiter_reg <= delimiter_next;
        end
    end

    assign b        = in_data.line_byte;
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cls.eol      = in_data.req_type;
        cls.is_quote = (b == csf_pkg::QUOTE_BYTE);
        cls.is_delim = (b == delimiter_reg);
        cls.is_space = (b == csf_pkg::SPACE_BYTE) ||
                       ((b >= csf_pkg::TAB_BYTE) && (b <= csf_pkg::CR_BYTE));
    end

endmodule

// File: src/csf_queue.sv
// Two-entry queue of classified beats between the front and the back.
module csf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csf_pkg::cls_t   push_data,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output csf_pkg::cls_t   head_data
);

    csf_pkg::cls_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign do_push    = push && (count_reg != 2'd2);
    assign do_pop     = pop && (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/csf_back.sv
// Back end: field parsing state machine and the result register.
module csf_back #(
    parameter logic [31:0] LINE_LIMIT = 32'd65535
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  csf_pkg::cls_t   head_data,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output csf_pkg::rsp_t   out_data
);

    localparam logic [15:0] POS_CAP =
        (LINE_LIMIT < 32'd65535) ? LINE_LIMIT[15:0] : 16'hFFFF;

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_PLAIN  = 3'd1;
    localparam logic [2:0] MODE_QUOTED = 3'd2;
    localparam logic [2:0] MODE_QPEND  = 3'd3;
    localparam logic [2:0] MODE_AFTER  = 3'd4;

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] line_pos_reg, line_pos_next;
    logic [15:0] fbegin_reg, fbegin_next;
    logic [15:0] first_ns_reg, first_ns_next;
    logic [15:0] end_ns_reg, end_ns_next;
    logic        seen_reg, seen_next;
    logic        ovf_reg, ovf_next;
    logic        out_valid_reg, out_valid_next;
    csf_pkg::rsp_t rsp_reg, rsp_next;

    logic        step, emit, open_field, ovf_now;
    logic [15:0] p, np;
    logic [15:0] cur_off, cur_len;
    logic        cur_q;

    function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
        span = (hi >= lo) ? (hi - lo) : 16'd0;
    endfunction

    assign step      = head_valid && (!out_valid_reg || out_ready);
    assign pop       = step;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    assign p       = (line_pos_reg >= POS_CAP) ? POS_CAP : line_pos_reg;
    assign np      = (p < POS_CAP) ? (p + 16'd1) : POS_CAP;
    assign ovf_now = ovf_reg || (line_pos_reg >= POS_CAP);

    // The field that is open now, as it would be reported.
    always_comb
    begin
        case (mode_reg)
            MODE_PLAIN:
            begin
                cur_q   = 1'b0;
                cur_off = seen_reg ? first_ns_reg : fbegin_reg;
                cur_len = seen_reg ? span(first_ns_reg, end_ns_reg) : 16'd0;
            end
            MODE_QUOTED:
            begin
                cur_q   = 1'b1;
                cur_off = fbegin_reg;
                cur_len = span(fbegin_reg, line_pos_reg);
            end
            MODE_QPEND, MODE_AFTER:
            begin
                cur_q   = 1'b1;
                cur_off = fbegin_reg;
                cur_len = span(fbegin_reg, end_ns_reg);
            end
            default:
            begin
                cur_q   = 1'b0;
                cur_off = fbegin_reg;
                cur_len = 16'd0;
            end
        endcase
    end

    always_comb
    begin
        mode_next     = mode_reg;
        line_pos_next = line_pos_reg;
        fbegin_next   = fbegin_reg;
        first_ns_next = first_ns_reg;
        end_ns_next   = end_ns_reg;
        seen_next     = seen_reg;
        ovf_next      = ovf_reg;
        rsp_next      = rsp_reg;
        emit          = 1'b0;
        open_field    = 1'b0;

        if (step)
        begin
            if (head_data.eol)
            begin
                emit          = 1'b1;
                rsp_next      = '{cur_off, cur_len, cur_q, 1'b1, ovf_reg};
                mode_next     = MODE_START;
                line_pos_next = 16'd0;
                fbegin_next   = 16'd0;
                first_ns_next = 16'd0;
                end_ns_next   = 16'd0;
                seen_next     = 1'b0;
                ovf_next      = 1'b0;
            end
            else
            begin
                ovf_next      = ovf_now;
                line_pos_next = np;
                rsp_next      = '{cur_off, cur_len, cur_q, 1'b0, ovf_now};
                case (mode_reg)
                    MODE_START:
                    begin
                        if (head_data.is_quote)
                        begin
                            fbegin_next = np;
                            mode_next   = MODE_QUOTED;
                        end
                        else if (head_data.is_delim)
                        begin
                            emit       = 1'b1;
                            open_field = 1'b1;
                            rsp_next   = '{p, 16'd0, 1'b0, 1'b0, ovf_now};
                        end
                        else
                        begin
                            fbegin_next = p;
                            mode_next   = MODE_PLAIN;
                            if (!head_data.is_space)
                            begin
                                first_ns_next = p;
                                end_ns_next   = np;
                                seen_next     = 1'b1;
                            end
                        end
                    end
                    MODE_PLAIN:
                    begin
                        if (head_data.is_delim)
                        begin
                            emit       = 1'b1;
                            open_field = 1'b1;
                        end
                        else if (!head_data.is_space)
                        begin
                            if (!seen_reg)
                            begin
                                first_ns_next = p;
                                seen_next     = 1'b1;
                            end
                            end_ns_next = np;
                        end
                    end
                    MODE_QUOTED:
                    begin
                        if (head_data.is_quote)
                        begin
                            end_ns_next = p;
                            mode_next   = MODE_QPEND;
                        end
                    end
                    MODE_QPEND:
                    begin
                        if (head_data.is_quote)
                        begin
                            mode_next = MODE_QUOTED;
                        end
                        else if (head_data.is_delim)
                        begin
                            emit       = 1'b1;
                            open_field = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_AFTER;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_AFTER;
                        if (head_data.is_delim)
                        begin
                            emit       = 1'b1;
                            open_field = 1'b1;
                        end
                    end
                endcase

                if (open_field)
                begin
                    mode_next     = MODE_START;
                    fbegin_next   = np;
                    first_ns_next = 16'd0;
                    end_ns_next   = 16'd0;
                    seen_next     = 1'b0;
                end
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_START;
            line_pos_reg  <= 16'd0;
            fbegin_reg    <= 16'd0;
            first_ns_reg  <= 16'd0;
            end_ns_reg    <= 16'd0;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            line_pos_reg  <= line_pos_next;
            fbegin_reg    <= fbegin_next;
            first_ns_reg  <= first_ns_next;
            end_ns_reg    <= end_ns_next;
            seen_reg      <= seen_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// File: src/csv_field_splitter.sv
// Top level of the delimited-line field splitter.
//
//   Channel   Direction  Signals                      Beat
//   in        input      in_valid/in_ready/in_data    one line byte or end of line
//   out       output     out_valid/out_ready/out_data one field: offset, length, flags
//   cfg       input      cfg_we/cfg_wdata             new delimiter byte
//
// One input beat is taken per cycle while the queue is not full; an accepted beat
// goes into the queue, then into the result register. The rate is set by the
// back-end parser state machine, which handles one classified beat per cycle
// unless an output stall holds it. Reset (rst_n low) clears the parser state,
// empties the queue and sets the delimiter to a comma. An output stall holds
// the result register and lets the two-entry queue fill; only then in_ready drops.
module csv_field_splitter #(
    parameter logic [31:0] LINE_LIMIT = 32'd65535
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_wdata,
    input  logic            in_valid,
    output logic            in_ready,
    input  csf_pkg::req_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output csf_pkg::rsp_t   out_data
);

    // Saturation point of line positions, used by the checks below.
    localparam logic [15:0] POS_CAP =
        (LINE_LIMIT < 32'd65535) ? LINE_LIMIT[15:0] : 16'hFFFF;

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    csf_pkg::cls_t front_cls;
    csf_pkg::cls_t q_head;

    // The front end compares each byte against the quote, the delimiter and
    // the whitespace set, so the back end only sees four class bits.
    csf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .q_full    (q_full),
        .in_ready  (in_ready),
        .push      (q_push),
        .cls       (front_cls)
    );

    // The queue decouples input acceptance from output backpressure.
    csf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (front_cls),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // The back end tracks the open field and registers each finished one.
    csf_back #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_data  (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // An accepted beat must be waiting in the queue on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> q_valid)
    else $error("accepted beat missing from queue");

    // Consuming an end-of-line beat always produces the line's final field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.eol) |=> (out_valid && out_data.last_in_line))
    else $error("end of line without a final field");

    // A reported field never reaches past the saturated line position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (({1'b0, out_data.field_offset} + {1'b0, out_data.field_length})
                       <= {1'b0, POS_CAP}))
    else $error("field extends beyond the line limit");

endmodule
